// ----- hw/rtl/prae_pkg.sv -----
// ----------------------------------------------------------------------------
// prae_pkg
// Shared types, constants and CORDIC step functions of the plane rotation
// angle estimator.
// ----------------------------------------------------------------------------
package prae_pkg;

  localparam int COORD_WIDTH_DEF  = 20;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int DW       = 36;
  localparam int AW       = 29;
  localparam int NORM_POS = 29;
  localparam int OUT_PI   = 23040;

  localparam logic signed [AW-1:0] ANG_90    = AW'(47185920);
  localparam longint               KINV_BASE = 652032875;
  localparam longint               KINV_TAIL = 434688583;

  typedef struct packed {
    logic                 deg;
    logic                 mz;
    logic                 vzero;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [AW-1:0] va;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [AW-1:0] ra;
    logic signed [DW-1:0] keep;
    logic signed [DW-1:0] n1;
    logic signed [DW-1:0] m0;
    logic signed [DW-1:0] m1;
    logic signed [DW-1:0] m2;
    logic signed [15:0]   ax;
    logic signed [15:0]   ay;
    logic signed [15:0]   az;
  } core_t;

  function automatic logic signed [AW-1:0] atan_tab(int i);
    logic signed [AW-1:0] r;
    case (i)
      0:  r = AW'(23592960);
      1:  r = AW'(13927738);
      2:  r = AW'(7359034);
      3:  r = AW'(3735561);
      4:  r = AW'(1875029);
      5:  r = AW'(938429);
      6:  r = AW'(469329);
      7:  r = AW'(234679);
      8:  r = AW'(117341);
      9:  r = AW'(58671);
      10: r = AW'(29335);
      11: r = AW'(14668);
      12: r = AW'(7334);
      13: r = AW'(3667);
      14: r = AW'(1833);
      15: r = AW'(917);
      16: r = AW'(458);
      17: r = AW'(229);
      18: r = AW'(115);
      19: r = AW'(57);
      20: r = AW'(29);
      21: r = AW'(14);
      22: r = AW'(7);
      23: r = AW'(4);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] to_out(logic signed [AW-1:0] a);
    logic signed [AW-1:0]  s;
    logic signed [AW-12:0] r;
    s = a + AW'(2048);
    r = (AW-11)'(s >>> 12);
    if (r > (AW-11)'(OUT_PI)) begin
      r = r - (AW-11)'(2 * OUT_PI);
    end else if (r <= -(AW-11)'(OUT_PI)) begin
      r = r + (AW-11)'(2 * OUT_PI);
    end
    return 16'(r);
  endfunction

  function automatic core_t vec_pre(core_t s);
    core_t                r;
    logic signed [DW-1:0] t;
    r       = s;
    r.vzero = (s.vx == '0) && (s.vy == '0);
    r.va    = '0;
    if (s.vx < 0) begin
      if (s.vy >= 0) begin
        t    = s.vy;
        r.vy = -s.vx;
        r.vx = t;
        r.va = ANG_90;
      end else begin
        t    = -s.vy;
        r.vy = s.vx;
        r.vx = t;
        r.va = -ANG_90;
      end
    end
    return r;
  endfunction

  function automatic core_t vec_iter(core_t s, int i);
    core_t                r;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    r  = s;
    dx = s.vy >>> i;
    dy = s.vx >>> i;
    if (s.vy >= 0) begin
      r.vx = s.vx + dx;
      r.vy = s.vy - dy;
      r.va = s.va + atan_tab(i);
    end else begin
      r.vx = s.vx - dx;
      r.vy = s.vy + dy;
      r.va = s.va - atan_tab(i);
    end
    return r;
  endfunction

  function automatic core_t rot_pre(core_t s);
    core_t r;
    r = s;
    if (s.ra > ANG_90) begin
      r.rx = -s.ry;
      r.ry = s.rx;
      r.ra = s.ra - ANG_90;
    end else if (s.ra < -ANG_90) begin
      r.rx = s.ry;
      r.ry = -s.rx;
      r.ra = s.ra + ANG_90;
    end
    return r;
  endfunction

  function automatic core_t rot_iter(core_t s, int i);
    core_t                r;
    logic signed [DW-1:0] du;
    logic signed [DW-1:0] dv;
    r  = s;
    du = s.ry >>> i;
    dv = s.rx >>> i;
    if (s.ra >= 0) begin
      r.rx = s.rx - du;
      r.ry = s.ry + dv;
      r.ra = s.ra - atan_tab(i);
    end else begin
      r.rx = s.rx + du;
      r.ry = s.ry - dv;
      r.ra = s.ra + atan_tab(i);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/prae_in_if.sv -----
// ----------------------------------------------------------------------------
// prae_in_if
// Corner pair channel: valid, ready and two centred marker corners.
// ----------------------------------------------------------------------------
interface prae_in_if
  import prae_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] corner0_x;
  logic signed [CW-1:0] corner0_y;
  logic signed [CW-1:0] corner0_z;
  logic signed [CW-1:0] corner1_x;
  logic signed [CW-1:0] corner1_y;
  logic signed [CW-1:0] corner1_z;

  modport source (
    output valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
    input  ready
  );
  modport sink (
    input  valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
    output ready
  );
endinterface

// ----- hw/rtl/prae_out_if.sv -----
// ----------------------------------------------------------------------------
// prae_out_if
// Angle result channel: valid, ready, three angles and the degenerate flag.
// ----------------------------------------------------------------------------
interface prae_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_about_x;
  logic signed [15:0] angle_about_y;
  logic signed [15:0] angle_about_z;
  logic               degenerate;

  modport source (
    output valid, angle_about_x, angle_about_y, angle_about_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, angle_about_x, angle_about_y, angle_about_z, degenerate,
    output ready
  );
endinterface

// ----- hw/rtl/plane_rotation_angle_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// plane_rotation_angle_estimator_unit
// Tilt and roll of a square marker from its first two centred corners.
// ----------------------------------------------------------------------------
// One beat is taken every cycle while the result side drains. The pipe runs
// the four CORDIC passes in series (vectoring for the normal, vectoring for
// the X tilt beside the Y un-rotation, the X un-rotation, vectoring for the
// roll), each one register stage per iteration plus a pre-rotation stage,
// behind six stages of cross product and normalization. A stall freezes
// the whole pipe.
module plane_rotation_angle_estimator_unit
  import prae_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prae_in_if.sink    in_i,
  prae_out_if.source out_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int S   = CORDIC_STEPS;
  localparam int PS  = (CW > 31) ? 2 : 0;
  localparam int NW  = 2 * CW + 1 - PS;
  localparam int MW  = CW + 1;
  localparam int PW  = $clog2(NW);
  localparam int EW  = NW + 30;
  localparam int NCH = 4 * S + 7;
  localparam int NV  = NCH + 6;
  localparam longint KINV_L = KINV_BASE + (KINV_TAIL >> (2 * S));
  localparam logic signed [31:0] KINV = 32'(KINV_L);

  logic en;
  logic [NV-1:0] vld_q;

  assign en         = !vld_q[NV-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_i.valid};
    end
  end

  logic signed [CW-1:0]   a_q [3];
  logic signed [CW-1:0]   b_q [3];
  logic signed [2*CW-1:0] p_q [6];
  logic signed [MW-1:0]   mp_q [3];
  logic signed [NW-1:0]   n_q [3];
  logic signed [MW-1:0]   mn_q [3];
  logic signed [NW-1:0]   n3_q [3];
  logic signed [MW-1:0]   m3_q [3];
  logic [NW-1:0]          orn_q;
  logic [MW-1:0]          orm_q;
  logic signed [NW-1:0]   n4_q [3];
  logic signed [MW-1:0]   m4_q [3];
  logic [PW-1:0]          posn_q;
  logic [PW-1:0]          posm_q;
  logic                   nz_q;
  logic                   mnz_q;
  core_t                  norm_d;
  core_t                  norm_q;

  logic [NW-1:0] orn_d;
  logic [MW-1:0] orm_d;
  logic [PW-1:0] posn_d;
  logic [PW-1:0] posm_d;

  always_comb begin
    orn_d = '0;
    orm_d = '0;
    for (int j = 0; j < 3; j++) begin
      orn_d = orn_d | (n_q[j] < 0 ? NW'(-n_q[j]) : NW'(n_q[j]));
      orm_d = orm_d | (mn_q[j] < 0 ? MW'(-mn_q[j]) : MW'(mn_q[j]));
    end
  end

  always_comb begin
    posn_d = '0;
    posm_d = '0;
    for (int j = 0; j < NW; j++) begin
      if (orn_q[j]) posn_d = PW'(j);
    end
    for (int j = 0; j < MW; j++) begin
      if (orm_q[j]) posm_d = PW'(j);
    end
  end

  always_comb begin
    logic signed [EW-1:0] t;
    norm_d = '0;
    norm_d.deg = !nz_q;
    norm_d.mz  = !mnz_q;
    for (int j = 0; j < 3; j++) begin
      t = EW'(n4_q[j]);
      if (int'(posn_q) >= NORM_POS) t = t >>> (int'(posn_q) - NORM_POS);
      else t = t <<< (NORM_POS - int'(posn_q));
      case (j)
        0: norm_d.vy = DW'(t);
        1: norm_d.n1 = DW'(t);
        default: norm_d.vx = DW'(t);
      endcase
      t = EW'(m4_q[j]);
      if (int'(posm_q) >= NORM_POS) t = t >>> (int'(posm_q) - NORM_POS);
      else t = t <<< (NORM_POS - int'(posm_q));
      case (j)
        0: norm_d.m0 = DW'(t);
        1: norm_d.m1 = DW'(t);
        default: norm_d.m2 = DW'(t);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0] <= in_i.corner0_x;
      a_q[1] <= in_i.corner0_y;
      a_q[2] <= in_i.corner0_z;
      b_q[0] <= in_i.corner1_x;
      b_q[1] <= in_i.corner1_y;
      b_q[2] <= in_i.corner1_z;
      p_q[0] <= a_q[1] * b_q[2];
      p_q[1] <= a_q[2] * b_q[1];
      p_q[2] <= a_q[2] * b_q[0];
      p_q[3] <= a_q[0] * b_q[2];
      p_q[4] <= a_q[0] * b_q[1];
      p_q[5] <= a_q[1] * b_q[0];
      for (int j = 0; j < 3; j++) begin
        mp_q[j] <= MW'(a_q[j]) + MW'(b_q[j]);
        n_q[j]  <= NW'(p_q[2*j] >>> PS) - NW'(p_q[2*j+1] >>> PS);
        mn_q[j] <= mp_q[j];
        n3_q[j] <= n_q[j];
        m3_q[j] <= mn_q[j];
        n4_q[j] <= n3_q[j];
        m4_q[j] <= m3_q[j];
      end
      orn_q  <= orn_d;
      orm_q  <= orm_d;
      posn_q <= posn_d;
      posm_q <= posm_d;
      nz_q   <= orn_q != '0;
      mnz_q  <= orm_q != '0;
      norm_q <= norm_d;
    end
  end

  core_t st_q [NCH];
  core_t st_d [NCH];

  for (genvar k = 0; k < NCH; k++) begin : g_chain
    always_comb begin
      core_t                  s;
      logic signed [DW+31:0]  pr;
      logic signed [DW-1:0]   q;
      logic signed [15:0]     oy;
      s  = (k == 0) ? norm_q : st_q[(k == 0) ? 0 : k-1];
      pr = '0;
      q  = '0;
      oy = '0;
      if (k == 0) begin
        s = vec_pre(s);
      end else if (k <= S) begin
        s = vec_iter(s, k - 1);
      end else if (k == S + 1) begin
        pr   = (s.vzero ? DW'(0) : s.vx) * KINV;
        oy   = to_out(s.vzero ? AW'(0) : s.va);
        s.ay = (oy <= 0) ? oy + 16'(OUT_PI) : oy - 16'(OUT_PI);
        s.vx = DW'(pr >>> 30);
        s.vy = s.n1;
        s.rx = s.m2;
        s.ry = s.m0;
        s.ra = -(AW'(s.ay) <<< 12);
      end else if (k == S + 2) begin
        s = rot_pre(vec_pre(s));
      end else if (k <= 2 * S + 2) begin
        s = rot_iter(vec_iter(s, k - S - 3), k - S - 3);
      end else if (k == 2 * S + 3) begin
        s.ax   = to_out(s.vzero ? AW'(0) : s.va);
        pr     = s.rx * KINV;
        q      = DW'(pr >>> 30);
        s.keep = s.ry;
        s.rx   = s.m1;
        s.ry   = q;
        s.ra   = -(AW'(s.ax) <<< 12);
      end else if (k == 2 * S + 4) begin
        s = rot_pre(s);
      end else if (k <= 3 * S + 4) begin
        s = rot_iter(s, k - 2 * S - 5);
      end else if (k == 3 * S + 5) begin
        s.vy = s.keep;
        s.vx = s.rx;
        s    = vec_pre(s);
      end else if (k <= 4 * S + 5) begin
        s = vec_iter(s, k - 3 * S - 6);
      end else begin
        s.az = (s.mz || s.vzero) ? 16'sd0 : to_out(s.va);
        if (s.deg) begin
          s.ax = '0;
          s.ay = '0;
          s.az = '0;
        end
      end
      st_d[k] = s;
    end

    always_ff @(posedge clk_i) begin
      if (en) st_q[k] <= st_d[k];
    end
  end

  assign out_o.valid         = vld_q[NV-1];
  assign out_o.angle_about_x = st_q[NCH-1].ax;
  assign out_o.angle_about_y = st_q[NCH-1].ay;
  assign out_o.angle_about_z = st_q[NCH-1].az;
  assign out_o.degenerate    = st_q[NCH-1].deg;

endmodule

// ----- dv/plane_rotation_angle_estimator_unit_test.sv -----
// ----------------------------------------------------------------------------
// plane_rotation_angle_estimator_unit_test
// Drives corner pairs through the angle estimator with bursty input and a
// stalling result side. Each result is compared field by field with the
// known row result or an in-bench fixed-point model of normal, tilt, roll.
// ----------------------------------------------------------------------------
module plane_rotation_angle_estimator_unit_test;
  import prae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW    = COORD_WIDTH_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int PS    = (CW > 31) ? 2 : 0;
  localparam int LAT   = 4 * STEPS + 13;
  localparam int N_RND = 730;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               deg;
  } angles_t;

  typedef struct {
    longint c[6];
    bit     known;
    angles_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  prae_in_if #(.CW(CW)) in_i ();
  prae_out_if out_o ();

  plane_rotation_angle_estimator_unit #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_i.sink), .out_o(out_o.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  angles_t pending_angles[$];
  int      errors = 0;
  bit      done = 1'b0;

  longint atan_steps[24] = '{23592960, 13927738, 7359034, 3735561, 1875029, 938429,
    469329, 234679, 117341, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7, 4};

  function automatic longint kinv_q30();
    return KINV_BASE + (KINV_TAIL >> (2 * STEPS));
  endfunction

  function automatic bit scale_vec(ref longint v[3]);
    longint m;
    m = 0;
    foreach (v[i]) if ((v[i] < 0 ? -v[i] : v[i]) > m) m = v[i] < 0 ? -v[i] : v[i];
    if (m == 0) return 1'b0;
    while (m >= (64'sd1 << 30)) begin
      foreach (v[i]) v[i] = v[i] >>> 1;
      m = m >>> 1;
    end
    while (m < (64'sd1 << 29)) begin
      foreach (v[i]) v[i] = v[i] * 2;
      m = m * 2;
    end
    return 1'b1;
  endfunction

  function automatic longint vector_angle(longint y, longint x, output longint mag);
    longint ang, t, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; ang = 47185920;
      end else begin
        t = -y; y = x; x = t; ang = -47185920;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += atan_steps[i];
      end else begin
        x -= dx; y += dy; ang -= atan_steps[i];
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic void rotate_vec(inout longint u, inout longint v, input longint th);
    longint t, du, dv;
    if (th > 47185920) begin
      t = u; u = -v; v = t; th -= 47185920;
    end else if (th < -47185920) begin
      t = u; u = v; v = -t; th += 47185920;
    end
    for (int i = 0; i < STEPS; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (th >= 0) begin
        u -= du; v += dv; th -= atan_steps[i];
      end else begin
        u += du; v -= dv; th += atan_steps[i];
      end
    end
  endfunction

  function automatic longint out_angle(longint a);
    longint r;
    r = (a + 2048) >>> 12;
    if (r > OUT_PI) r -= 2 * OUT_PI;
    else if (r <= -OUT_PI) r += 2 * OUT_PI;
    return r;
  endfunction

  function automatic angles_t marker_angles(longint c[6]);
    longint a[3], b[3], n[3], m[3];
    longint h, tmp, oy, ax, ay, az, k, u, v, p, q;
    angles_t r;
    k = kinv_q30();
    az = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (c[i] <<< (64 - CW)) >>> (64 - CW);
      b[i] = (c[i + 3] <<< (64 - CW)) >>> (64 - CW);
    end
    n[0] = ((a[1] * b[2]) >>> PS) - ((a[2] * b[1]) >>> PS);
    n[1] = ((a[2] * b[0]) >>> PS) - ((a[0] * b[2]) >>> PS);
    n[2] = ((a[0] * b[1]) >>> PS) - ((a[1] * b[0]) >>> PS);
    if (!scale_vec(n)) begin
      r = '{ax: '0, ay: '0, az: '0, deg: 1'b1};
      return r;
    end
    oy = vector_angle(n[0], n[2], h);
    h = (h * k) >>> 30;
    ax = out_angle(vector_angle(n[1], h, tmp));
    oy = out_angle(oy);
    ay = oy <= 0 ? oy + OUT_PI : oy - OUT_PI;
    for (int i = 0; i < 3; i++) m[i] = a[i] + b[i];
    if (scale_vec(m)) begin
      u = m[2];
      v = m[0];
      rotate_vec(u, v, -ay * 4096);
      p = m[1];
      q = (u * k) >>> 30;
      rotate_vec(p, q, -ax * 4096);
      az = out_angle(vector_angle(v, p, tmp));
    end
    r.ax = 16'(ax);
    r.ay = 16'(ay);
    r.az = 16'(az);
    r.deg = 1'b0;
    return r;
  endfunction

  localparam longint MX = 524287;
  localparam longint MN = -524288;
  row_t directed[$];

  task automatic add_row(longint a0, longint a1, longint a2, longint b0, longint b1,
                         longint b2, bit known = 1'b0, angles_t res = '0);
    row_t r;
    r.c = '{a0, a1, a2, b0, b1, b2};
    r.known = known;
    r.res = res;
    directed.push_back(r);
  endtask

  task automatic send_corners(longint c[6]);
    in_i.valid     <= 1'b1;
    in_i.corner0_x <= CW'(c[0]);
    in_i.corner0_y <= CW'(c[1]);
    in_i.corner0_z <= CW'(c[2]);
    in_i.corner1_x <= CW'(c[3]);
    in_i.corner1_y <= CW'(c[4]);
    in_i.corner1_z <= CW'(c[5]);
    do @(posedge clk_i); while (!in_i.ready);
  endtask

  task automatic rest_cycles(int n);
    if (n > 0) begin
      in_i.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic longint rand_coord(int mode);
    case (mode)
      0: return longint'($urandom_range(0, 2 * MX + 1)) + MN;
      1: return longint'($urandom_range(0, 2000)) - 1000;
      2: return $urandom_range(0, 1) ? MX : MN;
      default: return longint'($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  initial begin
    longint c[6];
    angles_t e;
    int burst, mode;
    in_i.valid <= 1'b0;
    in_i.corner0_x <= '0;
    in_i.corner0_y <= '0;
    in_i.corner0_z <= '0;
    in_i.corner1_x <= '0;
    in_i.corner1_y <= '0;
    in_i.corner1_z <= '0;
    add_row(0, 0, 0, 0, 0, 0, 1'b1, '{ax: '0, ay: '0, az: '0, deg: 1'b1});
    add_row(MX, MX, MX, MX, MX, MX, 1'b1, '{ax: '0, ay: '0, az: '0, deg: 1'b1});
    add_row(MN, MN, MN, MN, MN, MN, 1'b1, '{ax: '0, ay: '0, az: '0, deg: 1'b1});
    add_row(1000, 0, 0, 2000, 0, 0, 1'b1, '{ax: '0, ay: '0, az: '0, deg: 1'b1});
    add_row(-65536, 65536, 0, 65536, 65536, 0);
    add_row(65536, 65536, 0, -65536, 65536, 0);
    add_row(65536, 0, 0, 0, 0, 65536);
    add_row(0, 0, 65536, 65536, 0, 0);
    add_row(65536, 0, 0, -65536, 0, 1);
    add_row(MX, 0, MN, MN, MX, 0);
    add_row(MN, MX, MX, MX, MN, MX);
    add_row(MN, MN, 0, MX, MN, MX);
    add_row(1, 0, 0, 0, 1, 0);
    add_row(-1, -1, 1, 1, -1, -1);
    add_row(100, -200, 300, -100, 200, 301);
    add_row(-65536, -65536, 0, 65536, -65536, 0);
    add_row(0, 65536, 65536, 0, -65536, 65536);
    add_row(-32768, 0, 65536, 32768, 0, -65535);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      e = marker_angles(directed[i].c);
      if (directed[i].known && e != directed[i].res)
        $display("%0t predictor disagrees with table row %0d", $time, i);
      pending_angles.push_back(directed[i].known ? directed[i].res : e);
      send_corners(directed[i].c);
      if ($urandom_range(0, 3) == 0) rest_cycles($urandom_range(1, 4));
    end
    rest_cycles(1);
    while (pending_angles.size() != 0) @(posedge clk_i);
    for (int n = 0; n < N_RND;) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && n < N_RND; j++, n++) begin
        mode = $urandom_range(0, 3);
        foreach (c[i]) c[i] = rand_coord(mode);
        if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) c[i + 3] = c[i];
        if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) c[i + 3] = -c[i];
        pending_angles.push_back(marker_angles(c));
        send_corners(c);
      end
      rest_cycles($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
    end
    rest_cycles(1);
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 600;
      out_o.ready <= (stall_phase < 200) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    angles_t got, want;
    if (rst_ni && out_o.valid && out_o.ready) begin
      got = '{ax: out_o.angle_about_x, ay: out_o.angle_about_y,
              az: out_o.angle_about_z, deg: out_o.degenerate};
      if (pending_angles.size() == 0) begin
        $display("%0t unexpected beat: got %p", $time, got);
        errors++;
      end else begin
        want = pending_angles.pop_front();
        if (got.ax !== want.ax) begin
          $display("%0t angle_about_x exp %0d got %0d", $time, want.ax, got.ax);
          errors++;
        end
        if (got.ay !== want.ay) begin
          $display("%0t angle_about_y exp %0d got %0d", $time, want.ay, got.ay);
          errors++;
        end
        if (got.az !== want.az) begin
          $display("%0t angle_about_z exp %0d got %0d", $time, want.az, got.az);
          errors++;
        end
        if (got.deg !== want.deg) begin
          $display("%0t degenerate exp %0d got %0d", $time, want.deg, got.deg);
          errors++;
        end
      end
    end
  end

  initial begin
    #(2_000_000ns);
    $display("Mismatches found");
    $finish;
  end

endmodule
